/* sv/fdmt_pkg.sv */
// ============================================================================
// fdmt_pkg: shared types and constants of the fan duty block
// Widths, register indexes, duty curve constants, controller/datapath structs.
// ============================================================================
`default_nettype none

package fdmt_pkg;

    localparam int MAX_SENSORS = 8;
    localparam int MAX_FANS    = 4;
    localparam int SENS_IDX_W  = $clog2(MAX_SENSORS);
    localparam int FAN_IDX_W   = $clog2(MAX_FANS);

    localparam int TEMP_W   = 16;
    localparam int PWM_W    = 16;
    localparam int DUTY_W   = 13;
    localparam int PROD_W   = DUTY_W + PWM_W;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_COUNT = 3'd0,
        REG_FAN_COUNT    = 3'd1,
        REG_FAN0_MAX     = 3'd2,
        REG_FAN1_MAX     = 3'd3,
        REG_FAN2_MAX     = 3'd4,
        REG_FAN3_MAX     = 3'd5
    } t_reg_idx;

    localparam logic signed [TEMP_W-1:0] LOW_CUT  = 16'sd400;
    localparam logic signed [TEMP_W-1:0] HIGH_CUT = 16'sd1200;
    localparam logic [DUTY_W-1:0] DUTY_LOW  = 13'd1600;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 13'd8000;

    // ceil(p/8000) = floor((p+7999)/64/125); 1/125 by reciprocal, 2^-31 scale
    localparam logic [PROD_W:0] ROUND_ADD = 30'd7999;
    localparam int              Z_W       = PROD_W + 1 - 6;
    localparam int              RECIP_W   = 25;
    localparam logic [RECIP_W-1:0] RECIP  = 25'd17179870;
    localparam int              RECIP_SH  = 31;

    typedef struct packed {
        logic store;
        logic clr_changed;
        logic scan_clr;
        logic scan_step;
        logic take_max;
        logic mul;
        logic rnd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_go;
        logic scan_last;
        logic max_same;
        logic no_fans;
        logic fan_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* sv/fdmt_ifs.sv */
// ============================================================================
// fdmt_ifs: request channels of the fan duty block
// Sensor reading channel and fan pwm channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface fdmt_sensor_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              sensor_index;
    logic signed [15:0]      temperature;
    logic                    end_of_frame;

    modport source (output valid, sensor_index, temperature, end_of_frame, input ready);
    modport sink   (input valid, sensor_index, temperature, end_of_frame, output ready);
endinterface

interface fdmt_fan_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fan_index;
    logic [15:0] pwm_value;
    logic        last_fan;

    modport source (output valid, fan_index, pwm_value, last_fan, input ready);
    modport sink   (input valid, fan_index, pwm_value, last_fan, output ready);
endinterface

`default_nettype wire

/* sv/fdmt_datapath.sv */
// ============================================================================
// fdmt_datapath: sensor store, maximum scan, duty curve and pwm scaling
// Config registers, store with change flag, running max, multiply and
// reciprocal divide, output register.
// ============================================================================
`default_nettype none

module fdmt_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [fdmt_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [fdmt_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire [2:0]                            i_sensor_index,
    input  wire signed [fdmt_pkg::TEMP_W-1:0]    i_temperature,
    input  wire                                  i_end_of_frame,
    input  wire                                  i_out_ready,
    input  fdmt_pkg::t_dp_cmd                    i_cmd,
    output fdmt_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output logic [fdmt_pkg::FAN_IDX_W-1:0]       o_fan_index,
    output logic [fdmt_pkg::PWM_W-1:0]           o_pwm_value,
    output logic                                 o_last_fan
);

    logic [3:0]                              r_sensor_count;
    logic [2:0]                              r_fan_count;
    logic [fdmt_pkg::PWM_W-1:0]              r_max_pwm [fdmt_pkg::MAX_FANS];

    logic signed [fdmt_pkg::TEMP_W-1:0]      r_store [fdmt_pkg::MAX_SENSORS];
    logic                                    r_changed;
    logic signed [fdmt_pkg::TEMP_W-1:0]      r_cur_max;
    logic signed [fdmt_pkg::TEMP_W-1:0]      r_best;
    logic [fdmt_pkg::SENS_IDX_W-1:0]         r_scan_idx;
    logic [fdmt_pkg::FAN_IDX_W-1:0]          r_fan;
    logic [fdmt_pkg::DUTY_W-1:0]             r_duty;
    logic [fdmt_pkg::PROD_W-1:0]             r_prod;
    logic [fdmt_pkg::Z_W-1:0]                r_z;
    logic                                    r_out_valid;
    logic [fdmt_pkg::FAN_IDX_W-1:0]          r_out_fan;
    logic [fdmt_pkg::PWM_W-1:0]              r_out_pwm;
    logic                                    r_out_last;

    logic [3:0]                              n_sensors;
    logic [2:0]                              n_fans;
    logic                                    wr_hit;
    logic [fdmt_pkg::SENS_IDX_W-1:0]         wr_idx;
    logic signed [fdmt_pkg::TEMP_W-1:0]      scan_val;
    logic [13:0]                             duty_ramp;
    logic [fdmt_pkg::DUTY_W-1:0]             duty_new;
    logic [fdmt_pkg::PROD_W:0]               prod_rnd;
    logic [fdmt_pkg::Z_W+fdmt_pkg::RECIP_W-1:0] quot_full;
    logic                                    out_free;

    always_comb begin
        n_sensors = r_sensor_count;
        if (r_sensor_count == 4'd0) begin
            n_sensors = 4'd1;
        end else if (r_sensor_count > 4'(fdmt_pkg::MAX_SENSORS)) begin
            n_sensors = 4'(fdmt_pkg::MAX_SENSORS);
        end
        n_fans = (r_fan_count > 3'(fdmt_pkg::MAX_FANS)) ? 3'(fdmt_pkg::MAX_FANS) : r_fan_count;
    end

    assign wr_idx   = i_sensor_index[fdmt_pkg::SENS_IDX_W-1:0];
    assign wr_hit   = ({1'b0, i_sensor_index} < n_sensors) && (r_store[wr_idx] != i_temperature);
    assign scan_val = r_store[r_scan_idx];

    always_comb begin
        duty_ramp = {r_best[10:0], 3'b000} - 14'd1600;
        if (r_best <= fdmt_pkg::LOW_CUT) begin
            duty_new = fdmt_pkg::DUTY_LOW;
        end else if (r_best >= fdmt_pkg::HIGH_CUT) begin
            duty_new = fdmt_pkg::DUTY_FULL;
        end else begin
            duty_new = duty_ramp[fdmt_pkg::DUTY_W-1:0];
        end
    end

    assign prod_rnd  = {1'b0, r_prod} + fdmt_pkg::ROUND_ADD;
    assign quot_full = (fdmt_pkg::Z_W+fdmt_pkg::RECIP_W)'(r_z) *
                       (fdmt_pkg::Z_W+fdmt_pkg::RECIP_W)'(fdmt_pkg::RECIP);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_status.frame_go  = i_end_of_frame && (r_changed || wr_hit);
    assign o_status.scan_last = ({1'b0, r_scan_idx} == (n_sensors - 4'd1));
    assign o_status.max_same  = (r_best == r_cur_max);
    assign o_status.no_fans   = (n_fans == 3'd0);
    assign o_status.fan_last  = ({1'b0, r_fan} == (n_fans - 3'd1));
    assign o_status.out_free  = out_free;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count <= 4'd8;
            r_fan_count    <= 3'd4;
            for (int k = 0; k < fdmt_pkg::MAX_FANS; k++) begin
                r_max_pwm[k] <= 16'd255;
            end
            for (int k = 0; k < fdmt_pkg::MAX_SENSORS; k++) begin
                r_store[k] <= '0;
            end
            r_changed   <= 1'b0;
            r_cur_max   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fdmt_pkg::REG_SENSOR_COUNT: r_sensor_count <= i_cfg_data[3:0];
                    fdmt_pkg::REG_FAN_COUNT:    r_fan_count    <= i_cfg_data[2:0];
                    fdmt_pkg::REG_FAN0_MAX:     r_max_pwm[0]   <= i_cfg_data;
                    fdmt_pkg::REG_FAN1_MAX:     r_max_pwm[1]   <= i_cfg_data;
                    fdmt_pkg::REG_FAN2_MAX:     r_max_pwm[2]   <= i_cfg_data;
                    fdmt_pkg::REG_FAN3_MAX:     r_max_pwm[3]   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store && wr_hit) begin
                r_store[wr_idx] <= i_temperature;
            end
            if (i_cmd.clr_changed) begin
                r_changed <= 1'b0;
            end else if (i_cmd.store && wr_hit) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.take_max) begin
                r_cur_max <= r_best;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            if (r_scan_idx == '0 || scan_val > r_best) begin
                r_best <= scan_val;
            end
        end
        if (i_cmd.take_max) begin
            r_duty <= duty_new;
            r_fan  <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= fdmt_pkg::PROD_W'(r_duty) * fdmt_pkg::PROD_W'(r_max_pwm[r_fan]);
        end
        if (i_cmd.rnd) begin
            r_z <= prod_rnd[fdmt_pkg::PROD_W:6];
        end
        if (i_cmd.emit) begin
            r_out_fan  <= r_fan;
            r_out_pwm  <= quot_full[fdmt_pkg::RECIP_SH +: fdmt_pkg::PWM_W];
            r_out_last <= o_status.fan_last;
            r_fan      <= r_fan + 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fan_index = r_out_fan;
    assign o_pwm_value = r_out_pwm;
    assign o_last_fan  = r_out_last;

endmodule

`default_nettype wire

/* sv/fdmt_ctrl.sv */
// ============================================================================
// fdmt_ctrl: sequencer of the fan duty block
// Accepts readings, runs the maximum scan, the change check and one
// multiply / round / emit pass per fan.
// ============================================================================
`default_nettype none

module fdmt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  fdmt_pkg::t_dp_status   i_status,
    output fdmt_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MUL,
        S_RND,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.store = 1'b1;
                    if (i_status.frame_go) begin
                        o_cmd.clr_changed = 1'b1;
                        o_cmd.scan_clr    = 1'b1;
                        n_state           = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.max_same) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.take_max = 1'b1;
                    n_state = i_status.no_fans ? S_IDLE : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.fan_last ? S_IDLE : S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");

    a_frame_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.frame_go |=> !r_in_ready && r_state == S_SCAN)
        else $error("frame end did not start scan");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free && r_state == S_EMIT)
        else $error("emit without free output");

endmodule

`default_nettype wire

/* sv/fan_duty_from_max_temperature_core.sv */
// ============================================================================
// fan_duty_from_max_temperature_core: fan pwm from hottest sensor
// Sequence: a reading without frame end is stored; a frame end that changes
//   the maximum runs the scan of N sensors, the check, then a pass per fan.
// Throughput: one reading per cycle while idle; a frame end with changed
//   readings holds ready low for the scan and check, the fan passes and stalls.
// Reset (synchronous, active low): store, max, flags cleared; registers at
//   reset values; no clearing pass.
// ============================================================================
`default_nettype none

module fan_duty_from_max_temperature_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [fdmt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [fdmt_pkg::CFG_W-1:0]         i_cfg_data,
    fdmt_sensor_if.sink                       i_sensor,
    fdmt_fan_if.source                        o_fan
);

    fdmt_pkg::t_dp_cmd    cmd;
    fdmt_pkg::t_dp_status status;

    fdmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sensor.valid),
        .o_in_ready (i_sensor.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fdmt_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sensor_index (i_sensor.sensor_index),
        .i_temperature  (i_sensor.temperature),
        .i_end_of_frame (i_sensor.end_of_frame),
        .i_out_ready    (o_fan.ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_fan.valid),
        .o_fan_index    (o_fan.fan_index),
        .o_pwm_value    (o_fan.pwm_value),
        .o_last_fan     (o_fan.last_fan)
    );

endmodule

`default_nettype wire
